[rtl/core/stxq_pkg.sv]
// ----------------------------------------------------------------------------
// stxq_pkg: shared types and constants
// Types, codes and sizes used by the timer expiry queue and its cell chain.
// ----------------------------------------------------------------------------
package stxq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int DL_W        = 64;
  localparam int VAL_W       = 32;
  localparam int PER_W       = 16;
  localparam int ITER_W      = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [1:0] {
    KIND_EXPIRED  = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_ADD_OK   = 2'd2,
    KIND_ADD_FULL = 2'd3
  } kind_t;

  typedef enum logic {
    OPC_TICK = 1'b0,
    OPC_ADD  = 1'b1
  } opc_t;

  typedef enum logic {
    CFG_TASK_MARKER = 1'b0,
    CFG_TASK_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CHOP_NOP    = 2'd0,
    CHOP_INSERT = 2'd1,
    CHOP_POP    = 2'd2
  } chop_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_REARM = 2'd2
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [DL_W-1:0]  deadline;
    logic [VAL_W-1:0] payload;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    chop_t            op;
    logic [DL_W-1:0]  deadline;
    logic [VAL_W-1:0] payload;
  } chain_cmd_t;

endpackage

[rtl/core/stxq_cell.sv]
// ----------------------------------------------------------------------------
// stxq_cell: one slot of the sorted timer chain
// Holds one timer. On insert it keeps, takes the new timer or takes its left
// neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module stxq_cell
  import stxq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_cmd_t cmd,
  input  entry_t     left_ent,
  input  logic       left_gb,
  input  entry_t     right_ent,
  output entry_t     ent,
  output logic       gb
);

  entry_t ent_r;
  entry_t ent_nxt;

  // new timer goes behind this one
  assign gb  = ent_r.valid && (ent_r.deadline <= cmd.deadline);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      CHOP_INSERT: begin
        if (!gb) begin
          if (left_gb) begin
            ent_nxt.valid    = 1'b1;
            ent_nxt.deadline = cmd.deadline;
            ent_nxt.payload  = cmd.payload;
          end else begin
            ent_nxt = left_ent;
          end
        end
      end
      CHOP_POP: ent_nxt = right_ent;
      default:  ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

[rtl/core/stxq_chain.sv]
// ----------------------------------------------------------------------------
// stxq_chain: row of timer cells, earliest deadline in cell 0
// Cells exchange entries with their neighbors on every insert or pop.
// ----------------------------------------------------------------------------
module stxq_chain
  import stxq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  chain_cmd_t             cmd,
  output entry_t                 head,
  output logic [TIMER_SLOTS-1:0] valid_vec
);

  entry_t ent_a [TIMER_SLOTS];
  logic   gb_a  [TIMER_SLOTS];

  localparam entry_t EMPTY_ENT = '0;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    entry_t left_ent;
    logic   left_gb;
    entry_t right_ent;

    if (i == 0) begin : g_first
      // virtual sentinel in front of the head
      assign left_ent = EMPTY_ENT;
      assign left_gb  = 1'b1;
    end else begin : g_mid
      assign left_ent = ent_a[i-1];
      assign left_gb  = gb_a[i-1];
    end

    if (i == TIMER_SLOTS - 1) begin : g_last
      assign right_ent = EMPTY_ENT;
    end else begin : g_inner
      assign right_ent = ent_a[i+1];
    end

    stxq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (left_ent),
      .left_gb   (left_gb),
      .right_ent (right_ent),
      .ent       (ent_a[i]),
      .gb        (gb_a[i])
    );

    assign valid_vec[i] = ent_a[i].valid;
  end

  assign head = ent_a[0];

endmodule

[rtl/core/software_timer_expiry_queue_unit.sv]
// ----------------------------------------------------------------------------
// software_timer_expiry_queue_unit: earliest-deadline timer queue
// Tick counter plus a sorted chain of timer cells. Ticks pop due timers,
// re-arm the task-switch timer and end with a done item; adds insert if room.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   in      | in  | in_valid/in_stall  | opcode, new_deadline, new_value
//   out     | out | out_valid/out_stall| kind, expired_deadline, expired_value,
//           |     |                    | task_switch, last
//   cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// Add: result registered at accept.
// Tick: advance the counter, pop each expired timer, pop and re-insert each
//   re-armed task timer, and end the scan with done at the final head check;
//   at most TIMER_SLOTS pops per tick, all over cell 0 of the chain.
// One item at a time; a stalled output holds the scan, task re-arms go on.
// Reset (synchronous) empties the chain at once and zeroes the tick counter.
// ----------------------------------------------------------------------------
module software_timer_expiry_queue_unit
  import stxq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [DL_W-1:0]         in_new_deadline,
  input  logic signed [VAL_W-1:0] in_new_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_kind,
  output logic [DL_W-1:0]         out_expired_deadline,
  output logic signed [VAL_W-1:0] out_expired_value,
  output logic                    out_task_switch,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data
);

  state_t            state_r, state_nxt;
  logic [DL_W-1:0]   tick_r, tick_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              hit_r, hit_nxt;
  logic [DL_W-1:0]   rearm_dl_r;
  logic [VAL_W-1:0]  marker_r;
  logic [PER_W-1:0]  period_r;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [DL_W-1:0]   out_dl_r, out_dl_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;
  logic              out_ts_r, out_ts_nxt;
  logic              out_last_r, out_last_nxt;

  chain_cmd_t              cmd;
  entry_t                  head;
  logic [TIMER_SLOTS-1:0]  valid_vec;

  logic              out_free;
  logic              in_acc;
  logic              head_due;
  logic [PER_W-1:0]  period_eff;
  logic [DL_W:0]     rearm_sum;

  stxq_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .head      (head),
    .valid_vec (valid_vec)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign head_due = head.valid && (head.deadline <= tick_r)
                    && (iter_r != ITER_W'(TIMER_SLOTS));

  // zero period acts as one; saturate on wrap
  assign period_eff = (period_r == '0) ? PER_W'(1) : period_r;
  assign rearm_sum  = {1'b0, tick_r} + {{(DL_W + 1 - PER_W){1'b0}}, period_eff};

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    iter_nxt      = iter_r;
    hit_nxt       = hit_r;
    cmd.op        = CHOP_NOP;
    cmd.deadline  = in_new_deadline;
    cmd.payload   = in_new_value;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_dl_nxt    = out_dl_r;
    out_val_nxt   = out_val_r;
    out_ts_nxt    = out_ts_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OPC_ADD) begin
            if (!valid_vec[TIMER_SLOTS-1]) begin
              cmd.op       = CHOP_INSERT;
              out_kind_nxt = KIND_ADD_OK;
            end else begin
              out_kind_nxt = KIND_ADD_FULL;
            end
            out_valid_nxt = 1'b1;
            out_dl_nxt    = '0;
            out_val_nxt   = '0;
            out_ts_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
          end else begin
            tick_nxt  = tick_r + DL_W'(1);
            iter_nxt  = '0;
            hit_nxt   = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!head_due) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_DONE;
            out_dl_nxt    = '0;
            out_val_nxt   = '0;
            out_ts_nxt    = hit_r;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (head.payload == marker_r) begin
          cmd.op    = CHOP_POP;
          iter_nxt  = iter_r + ITER_W'(1);
          hit_nxt   = 1'b1;
          state_nxt = ST_REARM;
        end else if (out_free) begin
          cmd.op        = CHOP_POP;
          iter_nxt      = iter_r + ITER_W'(1);
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EXPIRED;
          out_dl_nxt    = head.deadline;
          out_val_nxt   = head.payload;
          out_ts_nxt    = 1'b0;
          out_last_nxt  = 1'b0;
        end
      end
      ST_REARM: begin
        // a slot was just freed by the pop
        cmd.op       = CHOP_INSERT;
        cmd.deadline = rearm_dl_r;
        cmd.payload  = marker_r;
        state_nxt    = ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      iter_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      marker_r    <= {1'b1, {(VAL_W - 1){1'b0}}};
      period_r    <= PER_W'(2);
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      iter_r      <= iter_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TASK_MARKER: marker_r <= cfg_data;
          CFG_TASK_PERIOD: period_r <= cfg_data[PER_W-1:0];
          default:         marker_r <= marker_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rearm_dl_r <= rearm_sum[DL_W] ? {DL_W{1'b1}} : rearm_sum[DL_W-1:0];
    out_kind_r <= out_kind_nxt;
    out_dl_r   <= out_dl_nxt;
    out_val_r  <= out_val_nxt;
    out_ts_r   <= out_ts_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_expired_deadline = out_dl_r;
  assign out_expired_value    = out_val_r;
  assign out_task_switch      = out_ts_r;
  assign out_last             = out_last_r;

  // valid cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + TIMER_SLOTS'(1))) == '0)
    else $error("chain valid bits are not a prefix");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CHOP_INSERT) |-> !valid_vec[TIMER_SLOTS-1])
    else $error("insert issued into a full chain");

  a_rearm_back: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REARM) |=> (state_r == ST_SCAN) && $stable(tick_r))
    else $error("re-arm did not return to scan");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= ITER_W'(TIMER_SLOTS))
    else $error("scan ran past the pop limit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CHOP_POP) |-> head.valid)
    else $error("pop of an empty chain");

endmodule
